// ----- rtl/quoted_token_splitter_top_defines.svh -----
// ----------------------------------------------------------------------------
// quoted token splitter assertion macros
// shared concurrent assertion forms used by the rtl files of the splitter
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_SPLITTER_TOP_DEFINES_SVH
`define QUOTED_TOKEN_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define QTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qts_pkg.sv -----
// ----------------------------------------------------------------------------
// qts_pkg
// types, byte codes and helpers shared by the quoted token splitter
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;

  localparam logic [7:0] COUNT_MAX        = 8'hff;
  localparam logic [7:0] COMMENT_CHAR_RST = 8'h23;

  // register index of comment_char
  localparam logic REG_COMMENT_CHAR = 1'b0;

  typedef struct packed {
    logic       in_quote;
    logic       in_escape;
    logic       in_comment;
    logic       token_open;
    logic [7:0] tokens_seen;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    in_quote:    1'b0,
    in_escape:   1'b0,
    in_comment:  1'b0,
    token_open:  1'b0,
    tokens_seen: 8'd0
  };

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       token_end;
    logic       last_result;
    logic       line_done;
    logic [7:0] token_count;
    logic       unterminated;
  } res_t;

  // up to two results caused by one item, in delivery order
  typedef struct packed {
    logic       res0_valid;
    res_t       res0;
    logic       res1_valid;
    res_t       res1;
  } step_out_t;

  function automatic logic is_space_byte(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_LOWER_T) r = CH_TAB;
    else if (c == CH_LOWER_R) r = CH_CR;
    else if (c == CH_LOWER_N) r = CH_LF;
    return r;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/quoted_token_splitter_top.sv -----
// ----------------------------------------------------------------------------
// quoted_token_splitter_top
// shell-style line tokenizer with quotes, escapes and comments
// ----------------------------------------------------------------------------
// Bytes of a line come in one item per cycle while in_ready is high, with
// last_of_line on the final byte. Every byte is decoded in the cycle it is
// accepted: the line state (quote, escape, comment, open token, token count)
// updates at that edge and the zero, one or two results it causes go into a
// four-entry result queue. Results leave the queue one per cycle on the
// output channel while out_ready is high. The final byte of a line causes
// two results when it also yields a token byte or a token end; every other
// byte causes at most one. The input is taken whenever the queue holds two
// results or fewer, so items flow at one a cycle while the output side keeps
// up; each two-result byte leaves the queue one result deeper until a
// result-free byte or an idle input cycle lets it drain, and the input stalls
// while it holds three or more. A result is visible on the outputs in the
// cycle after its item is accepted, at the earliest. comment_char lives at
// byte address 0 of the register port and resets to '#'.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_token_splitter_top import qts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_in,
  input  wire logic        last_of_line,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             char_valid,
  output logic [7:0]       char_out,
  output logic             token_end,
  output logic             last_result,
  output logic             line_done,
  output logic [7:0]       token_count,
  output logic             unterminated
);

`include "quoted_token_splitter_top_defines.svh"

  // configuration register
  logic [7:0]  comment_char;
  logic        reg_wr;
  logic        reg_idx;

  // line state, advanced once per accepted item
  line_state_t line_state;
  line_state_t line_state_next;

  step_out_t   step_out;
  logic        in_accept;
  res_t        head;

  // word-aligned register select; low two address bits are byte lanes
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && (reg_idx == REG_COMMENT_CHAR);
  assign prdata  = (reg_idx == REG_COMMENT_CHAR) ? {24'd0, comment_char} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_char <= COMMENT_CHAR_RST;
    end else if (reg_wr) begin
      comment_char <= pwdata[7:0];
    end
  end

  // byte decode: whitespace, quotes, escapes, comment start, line flush
  qts_step u_step (
    .comment_char (comment_char),
    .cur          (line_state),
    .char_in      (char_in),
    .last_of_line (last_of_line),
    .state_next   (line_state_next),
    .step_out     (step_out)
  );

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state <= LINE_CLEAR;
    end else if (in_accept) begin
      line_state <= line_state_next;
    end
  end

  // result queue decouples the two sides of the block
  qts_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .space_ok  (in_ready),
    .push      (in_accept),
    .step_out  (step_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign char_valid   = head.char_valid;
  assign char_out     = head.char_out;
  assign token_end    = head.token_end;
  assign last_result  = head.last_result;
  assign line_done    = head.line_done;
  assign token_count  = head.token_count;
  assign unterminated = head.unterminated;

  // a line summary is always the final result of its byte
  `QTS_ASSERT_NOW(a_done_is_last, clk, rst, out_valid && line_done, last_result, "summary not last result")
  // summary fields stay zero on token results
  `QTS_ASSERT_NOW(a_plain_no_summary, clk, rst, out_valid && !line_done, (token_count == 8'd0) && !unterminated, "summary fields set on token result")
  // the end of a line returns all line state to idle
  `QTS_ASSERT_NEXT(a_line_clear, clk, rst, in_accept && last_of_line, line_state == LINE_CLEAR, "line state not cleared at end of line")
  // a token byte never carries a line summary
  `QTS_ASSERT_NOW(a_char_not_done, clk, rst, out_valid && char_valid, !line_done, "token byte marked as line summary")

endmodule

`default_nettype wire

// ----- rtl/qts_step.sv -----
// ----------------------------------------------------------------------------
// qts_step
// per-byte tokenizer logic: next line state and up to two results
// ----------------------------------------------------------------------------
`default_nettype none

module qts_step import qts_pkg::*; (
  input  wire logic [7:0]  comment_char,
  input  wire line_state_t cur,
  input  wire logic [7:0]  char_in,
  input  wire logic        last_of_line,
  output line_state_t      state_next,
  output step_out_t        step_out
);

  line_state_t mid;
  logic        cv;
  logic [7:0]  co;
  logic        te;
  logic        flush;
  logic [7:0]  count_final;

  always_comb begin
    mid = cur;
    cv  = 1'b0;
    co  = 8'd0;
    te  = 1'b0;
    if (cur.in_comment) begin
      // rest of line ignored
    end else if (cur.in_escape) begin
      cv = 1'b1;
      co = unescape(char_in);
      mid.token_open = 1'b1;
      mid.in_escape  = 1'b0;
    end else if (cur.in_quote) begin
      if (char_in == CH_BACKSLASH) begin
        mid.in_escape = 1'b1;
      end else if (char_in != CH_DQUOTE) begin
        cv = 1'b1;
        co = char_in;
        mid.token_open = 1'b1;
      end else begin
        // closing quote ends the token, even if empty
        mid.in_quote    = 1'b0;
        te              = 1'b1;
        mid.tokens_seen = sat_inc(cur.tokens_seen);
        mid.token_open  = 1'b0;
      end
    end else if (is_space_byte(char_in)) begin
      if (cur.token_open) begin
        te              = 1'b1;
        mid.tokens_seen = sat_inc(cur.tokens_seen);
        mid.token_open  = 1'b0;
      end
    end else if (char_in == CH_DQUOTE) begin
      if (cur.token_open) begin
        te              = 1'b1;
        mid.tokens_seen = sat_inc(cur.tokens_seen);
        mid.token_open  = 1'b0;
      end
      mid.in_quote = 1'b1;
    end else if (char_in == comment_char) begin
      mid.in_comment = 1'b1;
    end else begin
      cv = 1'b1;
      co = char_in;
      mid.token_open = 1'b1;
    end

    flush       = mid.in_quote || mid.token_open;
    count_final = flush ? sat_inc(mid.tokens_seen) : mid.tokens_seen;

    step_out.res0_valid            = cv || te;
    step_out.res0.char_valid       = cv;
    step_out.res0.char_out         = co;
    step_out.res0.token_end        = te;
    step_out.res0.last_result      = !last_of_line;
    step_out.res0.line_done        = 1'b0;
    step_out.res0.token_count      = 8'd0;
    step_out.res0.unterminated     = 1'b0;

    step_out.res1_valid            = last_of_line;
    step_out.res1.char_valid       = 1'b0;
    step_out.res1.char_out         = 8'd0;
    step_out.res1.token_end        = flush;
    step_out.res1.last_result      = 1'b1;
    step_out.res1.line_done        = 1'b1;
    step_out.res1.token_count      = count_final;
    step_out.res1.unterminated     = mid.in_quote;

    state_next = last_of_line ? LINE_CLEAR : mid;
  end

endmodule

`default_nettype wire

// ----- rtl/qts_res_fifo.sv -----
// ----------------------------------------------------------------------------
// qts_res_fifo
// 4-entry result queue, takes up to two per cycle, gives one when ready
// ----------------------------------------------------------------------------
`default_nettype none

module qts_res_fifo import qts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  output logic           space_ok,
  input  wire logic      push,
  input  wire step_out_t step_out,
  output logic           out_valid,
  input  wire logic      out_ready,
  output res_t           head
);

`include "quoted_token_splitter_top_defines.svh"

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          wr_first;
  logic          wr_second;
  res_t          first_res;
  logic [CW-1:0] n_push;
  logic          pop;

  always_comb begin
    wr_first  = push && (step_out.res0_valid || step_out.res1_valid);
    wr_second = push && step_out.res0_valid && step_out.res1_valid;
    first_res = step_out.res0_valid ? step_out.res0 : step_out.res1;
    n_push    = CW'(wr_first) + CW'(wr_second);
    pop       = out_valid && out_ready;
    count_next = count + n_push - CW'(pop);
  end

  // room for the two results one item can cause
  assign space_ok  = (count <= CW'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      mem[wr_ptr] <= first_res;
    end
    if (wr_second) begin
      mem[wr_ptr + AW'(1)] <= step_out.res1;
    end
  end

  `QTS_ASSERT_NOW(a_fifo_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "result queue overflow")
  `QTS_ASSERT_NOW(a_fifo_push_room, clk, rst, push, space_ok, "push without room")
  `QTS_ASSERT_NEXT(a_fifo_drain, clk, rst, (count == CW'(1)) && pop && !wr_first, !out_valid, "queue not empty after last pop")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quoted token splitter: a directed table, a
// saturating line, then random lines under several comment bytes and traffic
// mixes, checked by a cycle-free tokenizer model kept alongside the stimulus
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import qts_pkg::*;

  // run guard, far above the slowest legal run (about 1300 items, two results
  // each, every result waiting out long random stalls)
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEGMENT_ITEMS = 22;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned OVERFLOW_TOKENS = 260;
  localparam logic [2:0] COMMENT_CHAR_ADDR = 3'(4 * REG_COMMENT_CHAR);
  localparam logic [7:0] CH_LETTER_A = 8'h61;
  localparam logic [7:0] CH_LETTER_B = 8'h62;
  localparam logic [7:0] CH_LETTER_C = 8'h63;
  localparam logic [7:0] CH_LETTER_Q = 8'h71;
  localparam logic [7:0] CH_LETTER_X = 8'h78;

  // one row of the directed table; typed rows carry their results by hand
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    int         n;
    res_t       r0;
    res_t       r1;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  logic       in_valid = 1'b0;
  wire        in_ready;
  logic [7:0] char_in = '0;
  logic       last_of_line = 1'b0;

  wire        out_valid;
  logic       out_ready = 1'b0;
  wire        char_valid;
  wire  [7:0] char_out;
  wire        token_end;
  wire        last_result;
  wire        line_done;
  wire  [7:0] token_count;
  wire        unterminated;

  // hand-typed results riding along with the item on the input side
  bit   use_typed = 1'b0;
  int   typed_n = 0;
  res_t typed_r0 = '0;
  res_t typed_r1 = '0;

  // model copy of the line state and of the comment register
  logic       mdl_in_quote;
  logic       mdl_in_escape;
  logic       mdl_in_comment;
  logic       mdl_token_open;
  logic [7:0] mdl_tokens;
  logic [7:0] mdl_comment_char;

  res_t pending_results[$];
  logic [7:0] line_bytes[$];
  stim_row_t directed_rows[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned items_in = 0;
  int unsigned results_out = 0;
  int unsigned cycles = 0;

  quoted_token_splitter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .last_of_line (last_of_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_valid   (char_valid),
    .char_out     (char_out),
    .token_end    (token_end),
    .last_result  (last_result),
    .line_done    (line_done),
    .token_count  (token_count),
    .unterminated (unterminated)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // tokenizer model
  // ---------------------------------------------------------------------------

  // whitespace is tab through carriage return, plus space
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] escaped_byte(input logic [7:0] c);
    case (c)
      CH_LOWER_T: return CH_TAB;
      CH_LOWER_R: return CH_CR;
      CH_LOWER_N: return CH_LF;
      default:    return c;
    endcase
  endfunction

  // token counter holds at its top value
  function automatic void bump_tokens();
    if (mdl_tokens != COUNT_MAX) mdl_tokens = mdl_tokens + 8'd1;
  endfunction

  function automatic void clear_line_state();
    mdl_in_quote = 1'b0;
    mdl_in_escape = 1'b0;
    mdl_in_comment = 1'b0;
    mdl_token_open = 1'b0;
    mdl_tokens = 8'd0;
  endfunction

  // advances the model by one byte, returns how many results it causes
  function automatic int tokenize_byte(input logic [7:0] c, input logic last,
                                       output res_t first, output res_t second);
    res_t body;
    res_t tail;
    logic flush;
    int n;
    body = '0;
    tail = '0;
    first = '0;
    second = '0;
    n = 0;
    if (mdl_in_comment) begin
      // rest of the line is ignored
    end else if (mdl_in_escape) begin
      body.char_valid = 1'b1;
      body.char_out = escaped_byte(c);
      mdl_token_open = 1'b1;
      mdl_in_escape = 1'b0;
    end else if (mdl_in_quote) begin
      if (c == CH_BACKSLASH) begin
        mdl_in_escape = 1'b1;
      end else if (c != CH_DQUOTE) begin
        body.char_valid = 1'b1;
        body.char_out = c;
        mdl_token_open = 1'b1;
      end else begin
        // closing quote always ends a token, empty or not
        mdl_in_quote = 1'b0;
        body.token_end = 1'b1;
        bump_tokens();
        mdl_token_open = 1'b0;
      end
    end else if (is_blank(c)) begin
      if (mdl_token_open) begin
        body.token_end = 1'b1;
        bump_tokens();
        mdl_token_open = 1'b0;
      end
    end else if (c == CH_DQUOTE) begin
      // opening quote ends a plain token first
      if (mdl_token_open) begin
        body.token_end = 1'b1;
        bump_tokens();
        mdl_token_open = 1'b0;
      end
      mdl_in_quote = 1'b1;
    end else if (c == mdl_comment_char) begin
      mdl_in_comment = 1'b1;
    end else begin
      body.char_valid = 1'b1;
      body.char_out = c;
      mdl_token_open = 1'b1;
    end

    if (body.char_valid || body.token_end) begin
      first = body;
      n = 1;
    end

    if (last) begin
      flush = mdl_in_quote || mdl_token_open;
      if (flush) bump_tokens();
      tail.token_end = flush;
      tail.line_done = 1'b1;
      tail.token_count = mdl_tokens;
      tail.unterminated = mdl_in_quote;
      if (n == 0) first = tail;
      else second = tail;
      n = n + 1;
      clear_line_state();
    end

    if (n == 1) first.last_result = 1'b1;
    if (n == 2) second.last_result = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // checking: out side first, then the item accepted at the same edge
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t p0;
    res_t p1;
    int n;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_out++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual char %0h end %0b done %0b",
                   $time, char_out, token_end, line_done);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("char_valid", want.char_valid, char_valid);
          check_field("char_out", want.char_out, char_out);
          check_field("token_end", want.token_end, token_end);
          check_field("last_result", want.last_result, last_result);
          check_field("line_done", want.line_done, line_done);
          check_field("token_count", want.token_count, token_count);
          check_field("unterminated", want.unterminated, unterminated);
        end
      end
      if (in_valid && in_ready) begin
        items_in++;
        // the model always runs so its state stays in step with typed rows
        n = tokenize_byte(char_in, last_of_line, p0, p1);
        if (use_typed) begin
          n = typed_n;
          p0 = typed_r0;
          p1 = typed_r1;
        end
        if (n > 0) pending_results.insert(pending_results.size(), p0);
        if (n > 1) pending_results.insert(pending_results.size(), p1);
      end
    end
  end

  // receiver stalls at the rate of the current traffic mix
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic res_t mk_res(input logic cv, input logic [7:0] co, input logic te,
                                  input logic lr, input logic ld, input logic [7:0] tc,
                                  input logic un);
    res_t r;
    r.char_valid = cv;
    r.char_out = co;
    r.token_end = te;
    r.last_result = lr;
    r.line_done = ld;
    r.token_count = tc;
    r.unterminated = un;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic last);
    stim_row_t row;
    row.ch = ch;
    row.last = last;
    row.typed = 1'b0;
    row.n = 0;
    row.r0 = '0;
    row.r1 = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_typed_row(input logic [7:0] ch, input logic last, input int n,
                                        input res_t r0, input res_t r1);
    stim_row_t row;
    row.ch = ch;
    row.last = last;
    row.typed = 1'b1;
    row.n = n;
    row.r0 = r0;
    row.r1 = r1;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid only drops while the sender idles, never between two back-to-back items
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed = 1'b0,
                           input int n = 0, input res_t r0 = '0, input res_t r1 = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in <= b;
    last_of_line <= last;
    use_typed <= typed;
    typed_n <= n;
    typed_r0 <= r0;
    typed_r1 <= r1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++) begin
      send_byte(line_bytes[i], (i == line_bytes.size() - 1));
    end
  endtask

  // sender holds off until every expected result is out and the block is quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    use_typed <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, then read back
  task automatic write_comment_char(input logic [7:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= COMMENT_CHAR_ADDR;
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mdl_comment_char = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("comment_char readback", value, prdata[7:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // builds one line, mostly well-formed pieces with some raw noise mixed in
  task automatic build_line();
    int pieces;
    int len;
    int pick;
    line_bytes.delete();
    pieces = $urandom_range(1, 6);
    for (int k = 0; k < pieces; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // plain token of printable bytes
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++) begin
          line_bytes.insert(line_bytes.size(), 8'($urandom_range(33, 126)));
        end
      end else if (pick < 55) begin
        // whitespace run
        len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(1)) line_bytes.insert(line_bytes.size(), CH_SPACE);
          else line_bytes.insert(line_bytes.size(), 8'($urandom_range(CH_TAB, CH_CR)));
        end
      end else if (pick < 80) begin
        // quoted string with escapes, left open now and then
        line_bytes.insert(line_bytes.size(), CH_DQUOTE);
        len = $urandom_range(0, 4);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(3) == 0) begin
            line_bytes.insert(line_bytes.size(), CH_BACKSLASH);
            case ($urandom_range(3))
              0:       line_bytes.insert(line_bytes.size(), CH_LOWER_T);
              1:       line_bytes.insert(line_bytes.size(), CH_LOWER_R);
              2:       line_bytes.insert(line_bytes.size(), CH_LOWER_N);
              default: line_bytes.insert(line_bytes.size(), 8'($urandom_range(255)));
            endcase
          end else begin
            line_bytes.insert(line_bytes.size(), 8'($urandom_range(32, 126)));
          end
        end
        if ($urandom_range(9) != 0) line_bytes.insert(line_bytes.size(), CH_DQUOTE);
      end else if (pick < 88) begin
        // comment and a tail that must be ignored
        line_bytes.insert(line_bytes.size(), mdl_comment_char);
        len = $urandom_range(0, 3);
        for (int j = 0; j < len; j++) begin
          line_bytes.insert(line_bytes.size(), 8'($urandom_range(255)));
        end
      end else begin
        // raw noise over the whole byte range
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          line_bytes.insert(line_bytes.size(), 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [7:0] comment_settings[6];
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    int unsigned sent;
    res_t none;

    none = '0;
    mdl_comment_char = COMMENT_CHAR_RST;
    clear_line_state();

    // comment byte settings: both extremes, whitespace and quote (their own
    // meaning must win), a random byte, and back to the reset value
    comment_settings[0] = 8'h00;
    comment_settings[1] = 8'hff;
    comment_settings[2] = CH_SPACE;
    comment_settings[3] = CH_DQUOTE;
    comment_settings[4] = 8'($urandom_range(255));
    comment_settings[5] = COMMENT_CHAR_RST;

    // traffic mixes: free flow, slow sender, slow receiver, both slow
    idle_mix[0] = 0;  stall_mix[0] = 0;
    idle_mix[1] = 84; stall_mix[1] = 0;
    idle_mix[2] = 0;  stall_mix[2] = 84;
    idle_mix[3] = 38; stall_mix[3] = 38;

    // directed table, comment byte at its reset value
    // single-byte line: one token byte, then the summary
    add_typed_row(CH_LETTER_A, 1'b1, 2, mk_res(1, CH_LETTER_A, 0, 0, 0, 0, 0),
                  mk_res(0, 8'h00, 1, 1, 1, 1, 0));
    // byte extremes form one token
    add_typed_row(8'h00, 1'b0, 1, mk_res(1, 8'h00, 0, 1, 0, 0, 0), none);
    add_typed_row(8'hff, 1'b1, 2, mk_res(1, 8'hff, 0, 0, 0, 0, 0),
                  mk_res(0, 8'h00, 1, 1, 1, 1, 0));
    // whitespace-only line: summary with no tokens
    add_typed_row(CH_SPACE, 1'b1, 1, mk_res(0, 8'h00, 0, 1, 1, 0, 0), none);
    // quoted string with every escape form
    add_row(CH_DQUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_LOWER_T, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_LOWER_R, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_LOWER_N, 1'b0);
    add_row(CH_BACKSLASH, 1'b0);
    add_row(CH_LETTER_Q, 1'b0);
    add_row(CH_DQUOTE, 1'b0);
    // plain token ended by an opening quote, then an empty quoted token
    add_row(CH_LETTER_X, 1'b0);
    add_row(CH_DQUOTE, 1'b0);
    add_row(CH_DQUOTE, 1'b0);
    // line ending inside an escape within a quote
    add_row(CH_DQUOTE, 1'b0);
    add_row(CH_BACKSLASH, 1'b1);
    // comment after a token swallows the rest, token still flushed at the end
    add_row(CH_LETTER_B, 1'b0);
    add_row(COMMENT_CHAR_RST, 1'b0);
    add_row(CH_LETTER_C, 1'b0);
    add_row(CH_DQUOTE, 1'b1);
    // backslash outside quotes is a plain byte
    add_row(CH_BACKSLASH, 1'b1);
    // line that ends right after an opening quote: empty token, unterminated
    add_typed_row(CH_DQUOTE, 1'b1, 1, mk_res(0, 8'h00, 1, 1, 1, 1, 1), none);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].n, directed_rows[i].r0, directed_rows[i].r1);
    end
    wait_drained();

    // one long line to push the token count into saturation
    line_bytes.delete();
    for (int i = 0; i < OVERFLOW_TOKENS; i++) begin
      line_bytes.insert(line_bytes.size(), CH_LETTER_A);
      line_bytes.insert(line_bytes.size(), CH_SPACE);
    end
    line_bytes.insert(line_bytes.size(), CH_LETTER_B);
    send_line();

    // random lines under every comment setting and traffic mix
    for (int ci = 0; ci < 6; ci++) begin
      wait_drained();
      write_comment_char(comment_settings[ci]);
      @(negedge clk);
      for (int mi = 0; mi < 4; mi++) begin
        send_idle_pct = idle_mix[mi];
        recv_stall_pct = stall_mix[mi];
        sent = 0;
        while (sent < SEGMENT_ITEMS) begin
          build_line();
          send_line();
          sent += line_bytes.size();
        end
      end
    end

    // drain, then let the block sit a little longer
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d results: directed table, saturating line,",
             items_in, results_out);
    $display("six comment bytes under four traffic mixes, %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/qts_pkg.sv
rtl/qts_step.sv
rtl/qts_res_fifo.sv
rtl/quoted_token_splitter_top.sv
test/tb.sv
